>>> sv/prbh_pkg.sv
// Package for the prime residue bit hash core: sizes, transaction types,
// controller commands and status. Used by every module of the block.
`default_nettype none
package prbh_pkg;
    localparam int MAX_TABLE   = 1024;
    localparam int TBL_AW      = $clog2(MAX_TABLE);
    localparam int SIZE_W      = 11;
    localparam int SMALL_LIMIT = 34;
    localparam int ROUND_BITS  = 32;
    localparam int POS_W       = $clog2(ROUND_BITS);
    localparam int PRIME_W     = 13;
    localparam int STEP_W      = 6;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_TABLE);

    typedef struct packed {
        logic              operation;
        logic [31:0]       value;
        logic [SIZE_W-1:0] passes;
    } t_in;

    typedef struct packed {
        logic [31:0] hash_value;
        logic        too_small;
    } t_out;

    typedef enum logic [3:0] {
        CMD_NONE  = 4'd0,
        CMD_LOAD  = 4'd1,
        CMD_CLR   = 4'd2,
        CMD_GINIT = 4'd3,
        CMD_PADD  = 4'd4,
        CMD_NCAND = 4'd5,
        CMD_NJ    = 4'd6,
        CMD_DIVC  = 4'd7,
        CMD_DIVV  = 4'd8,
        CMD_BINIT = 4'd9,
        CMD_BSTEP = 4'd10,
        CMD_REND  = 4'd11,
        CMD_ONES  = 4'd12
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
    } t_ctl;

    typedef struct packed {
        logic op;
        logic clr_last;
        logic n_le1;
        logic j_ge_cnt;
        logic p_sq_gt;
        logic count_last;
        logic div_done;
        logic rem_zero;
        logic pass_zero;
        logic tbl_small;
        logic bit_last;
    } t_sts;
endpackage
`default_nettype wire

>>> sv/prbh_div.sv
// Restoring remainder unit, one quotient bit per cycle.
// Depends on prbh_pkg.
`default_nettype none
module prbh_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [31:0]                 i_dividend,
    input  wire logic [prbh_pkg::PRIME_W-1:0] i_divisor,
    input  wire logic [prbh_pkg::STEP_W-1:0]  i_steps,
    output logic                             o_done,
    output logic [prbh_pkg::PRIME_W-1:0]     o_rem
);
    import prbh_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_cnt;
    logic [31:0]        r_dq;
    logic [PRIME_W-1:0] r_rem;
    logic [PRIME_W-1:0] r_dvs;
    logic [PRIME_W:0]   trial;
    logic [PRIME_W:0]   n_diff;
    logic [PRIME_W-1:0] n_rem;

    always_comb begin
        trial  = {r_rem, r_dq[31]};
        n_diff = trial - {1'b0, r_dvs};
        n_rem  = (trial >= {1'b0, r_dvs}) ? n_diff[PRIME_W-1:0] : trial[PRIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_steps;
            r_dq   <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dq  <= {r_dq[30:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

>>> sv/prbh_datapath.sv
// Datapath: size register, bit table and prime memories, counters and the
// hash accumulator. Depends on prbh_pkg and prbh_div.
`default_nettype none
module prbh_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [prbh_pkg::SIZE_W-1:0]  i_cfg_wdata,
    input  wire prbh_pkg::t_in                i_item,
    input  wire prbh_pkg::t_ctl               i_ctl,
    output prbh_pkg::t_sts                    o_sts,
    output prbh_pkg::t_out                    o_result
);
    import prbh_pkg::*;

    logic [SIZE_W-1:0]     r_size;
    logic [SIZE_W-1:0]     n_eff;
    logic [SIZE_W-1:0]     n_mod;
    logic                  r_op;
    logic [31:0]           r_value;
    logic [SIZE_W-1:0]     r_passes;
    logic [TBL_AW-1:0]     r_clr_idx;
    logic [SIZE_W-1:0]     r_count;
    logic [SIZE_W-1:0]     r_j;
    logic [PRIME_W-1:0]    r_cand;
    logic [PRIME_W-1:0]    r_p;
    logic [TBL_AW-1:0]     r_idx;
    logic [31:0]           r_sum;
    logic [POS_W-1:0]      r_pos;
    logic                  r_rv;
    logic [POS_W-1:0]      r_rpos;
    logic                  r_tbl_q;
    logic [31:0]           r_acc;
    logic                  r_tbl [MAX_TABLE];
    logic [PRIME_W-1:0]    r_pbuf [MAX_TABLE];
    logic                  tbl_we;
    logic [TBL_AW-1:0]     tbl_waddr;
    logic                  tbl_wbit;
    logic                  pb_we;
    logic [TBL_AW-1:0]     pb_waddr;
    logic [PRIME_W-1:0]    pb_wdata;
    logic                  div_start;
    logic [31:0]           div_dividend;
    logic [PRIME_W-1:0]    div_divisor;
    logic [STEP_W-1:0]     div_steps;
    logic                  div_done;
    logic [PRIME_W-1:0]    div_rem;
    logic [2*PRIME_W-1:0]  p_sq;
    logic [SIZE_W:0]       idx_inc;
    logic [SIZE_W:0]       cnt_inc;

    always_comb begin
        n_eff   = (r_size > SIZE_W'(MAX_TABLE)) ? SIZE_W'(MAX_TABLE) : r_size;
        n_mod   = n_eff - SIZE_W'(2);
        p_sq    = r_p * r_p;
        idx_inc = {{(SIZE_W-TBL_AW+1){1'b0}}, r_idx} + 1'b1;
        cnt_inc = {1'b0, r_count} + 1'b1;
    end

    always_comb begin
        tbl_we       = 1'b0;
        tbl_waddr    = r_clr_idx;
        tbl_wbit     = 1'b0;
        pb_we        = 1'b0;
        pb_waddr     = r_count[TBL_AW-1:0];
        pb_wdata     = r_cand;
        div_start    = 1'b0;
        div_dividend = r_value;
        div_divisor  = PRIME_W'(n_mod);
        div_steps    = STEP_W'(ROUND_BITS);
        unique case (i_ctl.cmd)
            CMD_CLR: begin
                tbl_we = 1'b1;
            end
            CMD_GINIT: begin
                pb_we    = (n_eff != '0);
                pb_waddr = '0;
                pb_wdata = PRIME_W'(2);
            end
            CMD_PADD: begin
                pb_we     = 1'b1;
                tbl_we    = 1'b1;
                tbl_waddr = TBL_AW'(r_count - 1'b1);
                tbl_wbit  = (r_cand[1:0] == 2'b01);
            end
            CMD_DIVC: begin
                div_start    = 1'b1;
                div_dividend = {r_cand, {(32-PRIME_W){1'b0}}};
                div_divisor  = r_p;
                div_steps    = STEP_W'(PRIME_W);
            end
            CMD_DIVV: begin
                div_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    prbh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wbit;
        end
        r_tbl_q <= r_tbl[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (pb_we) begin
            r_pbuf[pb_waddr] <= pb_wdata;
        end
        r_p <= r_pbuf[r_j[TBL_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_rv      <= 1'b0;
        end else begin
            r_rv <= (i_ctl.cmd == CMD_BSTEP);
            if (i_ctl.cmd == CMD_CLR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rpos <= r_pos;
        if (r_rv) begin
            r_acc[r_rpos] <= r_tbl_q;
        end
        unique case (i_ctl.cmd)
            CMD_LOAD: begin
                r_op     <= i_item.operation;
                r_value  <= i_item.value;
                r_passes <= i_item.passes;
            end
            CMD_GINIT: begin
                r_count <= (n_eff == '0) ? SIZE_W'(0) : SIZE_W'(1);
                r_cand  <= PRIME_W'(3);
                r_j     <= SIZE_W'(1);
            end
            CMD_PADD: begin
                r_count <= cnt_inc[SIZE_W-1:0];
                r_cand  <= r_cand + PRIME_W'(2);
                r_j     <= SIZE_W'(1);
            end
            CMD_NCAND: begin
                r_cand <= r_cand + PRIME_W'(2);
                r_j    <= SIZE_W'(1);
            end
            CMD_NJ: begin
                r_j <= r_j + 1'b1;
            end
            CMD_BINIT: begin
                r_idx <= div_rem[TBL_AW-1:0];
                r_sum <= r_value;
                r_pos <= '0;
            end
            CMD_BSTEP: begin
                r_sum <= r_sum + 1'b1;
                r_pos <= r_pos + 1'b1;
                if (r_sum == 32'hFFFF_FFFF || idx_inc == {1'b0, n_mod}) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= idx_inc[TBL_AW-1:0];
                end
            end
            CMD_REND: begin
                r_value  <= r_acc;
                r_passes <= r_passes - 1'b1;
            end
            CMD_ONES: begin
                r_value <= 32'hFFFF_FFFF;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.clr_last   = (r_clr_idx == TBL_AW'(MAX_TABLE - 1));
        o_sts.n_le1      = (n_eff <= SIZE_W'(1));
        o_sts.j_ge_cnt   = (r_j >= r_count);
        o_sts.p_sq_gt    = (p_sq > {{PRIME_W{1'b0}}, r_cand});
        o_sts.count_last = (cnt_inc == {1'b0, n_eff});
        o_sts.div_done   = div_done;
        o_sts.rem_zero   = (div_rem == '0);
        o_sts.pass_zero  = (r_passes == '0);
        o_sts.tbl_small  = (n_eff < SIZE_W'(SMALL_LIMIT));
        o_sts.bit_last   = (r_pos == POS_W'(ROUND_BITS - 1));
        o_result.hash_value = r_op ? r_value : 32'h0;
        o_result.too_small  = (n_eff < SIZE_W'(SMALL_LIMIT));
    end
endmodule
`default_nettype wire

>>> sv/prbh_ctrl.sv
// Controller state machine: sequences table clear, prime generation and
// hash rounds. Depends on prbh_pkg.
`default_nettype none
module prbh_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire prbh_pkg::t_sts  i_sts,
    output prbh_pkg::t_ctl       o_ctl,
    output logic                 o_busy,
    output logic                 o_done
);
    import prbh_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_CLR   = 12'b0000_0000_0010,
        S_GINIT = 12'b0000_0000_0100,
        S_GRD   = 12'b0000_0000_1000,
        S_GTST  = 12'b0000_0001_0000,
        S_GDIV  = 12'b0000_0010_0000,
        S_HCHK  = 12'b0000_0100_0000,
        S_HDIV  = 12'b0000_1000_0000,
        S_HBIT  = 12'b0001_0000_0000,
        S_HWAIT = 12'b0010_0000_0000,
        S_HEND  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rebuild;
    logic   n_rebuild;

    always_comb begin
        n_state   = r_state;
        n_rebuild = r_rebuild;
        o_ctl.cmd = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state   = S_HCHK;
                end
            end
            S_CLR: begin
                o_ctl.cmd = CMD_CLR;
                if (i_sts.clr_last) begin
                    n_state = r_rebuild ? S_GINIT : S_IDLE;
                end
            end
            S_GINIT: begin
                o_ctl.cmd = CMD_GINIT;
                n_state   = i_sts.n_le1 ? S_DONE : S_GRD;
            end
            S_GRD: begin
                n_state = S_GTST;
            end
            S_GTST: begin
                if (i_sts.j_ge_cnt || i_sts.p_sq_gt) begin
                    o_ctl.cmd = CMD_PADD;
                    n_state   = i_sts.count_last ? S_DONE : S_GRD;
                end else begin
                    o_ctl.cmd = CMD_DIVC;
                    n_state   = S_GDIV;
                end
            end
            S_GDIV: begin
                if (i_sts.div_done) begin
                    o_ctl.cmd = i_sts.rem_zero ? CMD_NCAND : CMD_NJ;
                    n_state   = S_GRD;
                end
            end
            S_HCHK: begin
                if (!i_sts.op) begin
                    n_rebuild = 1'b1;
                    n_state   = S_CLR;
                end else if (i_sts.pass_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.tbl_small) begin
                    o_ctl.cmd = CMD_ONES;
                    n_state   = S_DONE;
                end else begin
                    o_ctl.cmd = CMD_DIVV;
                    n_state   = S_HDIV;
                end
            end
            S_HDIV: begin
                if (i_sts.div_done) begin
                    o_ctl.cmd = CMD_BINIT;
                    n_state   = S_HBIT;
                end
            end
            S_HBIT: begin
                o_ctl.cmd = CMD_BSTEP;
                if (i_sts.bit_last) begin
                    n_state = S_HWAIT;
                end
            end
            S_HWAIT: begin
                n_state = S_HEND;
            end
            S_HEND: begin
                o_ctl.cmd = CMD_REND;
                n_state   = S_HCHK;
            end
            S_DONE: begin
                n_rebuild = 1'b0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_rebuild <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rebuild <= n_rebuild;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
endmodule
`default_nettype wire

>>> sv/prime_residue_bit_hash_core.sv
// Top level of the prime residue bit hash core: controller plus datapath.
// Depends on prbh_pkg, prbh_ctrl, prbh_datapath.
//
// Channel   Ports                       Handshake
// item      i_item (t_in)               start high and busy low at the edge
// result    o_result (t_out)            o_done high for one cycle
// config    i_cfg_we, i_cfg_wdata       written at the edge with i_cfg_we high
//
// A hash transaction with P passes runs P rounds before its result strobes:
// each round is a check, a pass through the shared remainder unit for the
// window start, a table bit read for each of the 32 hash bits, then the closing wait and end states.
// With P zero or a table size below 34 the check state passes straight to done.
// A rebuild clears all 1024 table entries, then runs trial division through
// the same remainder unit; after reset the table is cleared with busy high.
// The receiver cannot stall; each transaction yields one result.
`default_nettype none
module prime_residue_bit_hash_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire prbh_pkg::t_in               i_item,
    output logic                             o_done,
    output prbh_pkg::t_out                   o_result,
    input  wire logic                        i_cfg_we,
    input  wire logic [prbh_pkg::SIZE_W-1:0] i_cfg_wdata
);
    import prbh_pkg::*;

    t_ctl ctl;
    t_sts sts;

    prbh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    prbh_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_result    (o_result)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not make the core busy");

    a_rebuild_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !sts.op) |-> (o_result.hash_value == 32'h0))
        else $error("rebuild result is not zero");
endmodule
`default_nettype wire

>>> tb/tb_prime_residue_bit_hash_core.sv
// Self-checking testbench for prime_residue_bit_hash_core: directed table rows, then
// random rebuild and hash transactions checked against an in-bench predictor.
// Depends on prbh_pkg and the core RTL only.
`default_nettype none
module tb_prime_residue_bit_hash_core;
    import prbh_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000000;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int OP_REBUILD     = 0;
    localparam int OP_HASH        = 1;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in               i_item;
    logic              o_done;
    t_out              o_result;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;

    prime_residue_bit_hash_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    typedef struct {
        int          size;
        bit          op;
        logic [31:0] value;
        int          passes;
        bit          typed;
        logic [31:0] exp_hash;
        bit          exp_small;
    } t_row;

    bit          residue_bits[MAX_TABLE];
    int          size_reg;
    t_out        pending_results[$];
    int          mismatches;
    int          idle_cycles;
    int          sender_idle_pct;
    int          hash_count;
    int          rebuild_count;
    int          small_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int effective_size();
        return (size_reg > MAX_TABLE) ? MAX_TABLE : size_reg;
    endfunction

    function automatic void refill_residues(int n);
        int primes[MAX_TABLE];
        int cnt;
        int cand;
        bit is_prime;
        foreach (residue_bits[k]) residue_bits[k] = 1'b0;
        if (n == 0) return;
        primes[0] = 2;
        cnt = 1;
        cand = 3;
        while (cnt < n) begin
            is_prime = 1'b1;
            for (int j = 1; j < cnt; j++) begin
                if (primes[j] * primes[j] > cand) break;
                if (cand % primes[j] == 0) begin
                    is_prime = 1'b0;
                    break;
                end
            end
            if (is_prime) begin
                primes[cnt] = cand;
                cnt++;
            end
            cand += 2;
        end
        for (int k = 0; k + 1 < n; k++) residue_bits[k] = (primes[k + 1] % 4 == 1);
    endfunction

    function automatic logic [31:0] window_round(logic [31:0] v, int n);
        logic [31:0] r;
        logic [31:0] pos;
        int          idx;
        if (n < SMALL_LIMIT) return '1;
        r = '0;
        for (int i = 0; i < ROUND_BITS; i++) begin
            pos = v + 32'(i);
            idx = int'(pos % 32'(n - 2));
            r[i] = (idx < MAX_TABLE) && residue_bits[idx];
        end
        return r;
    endfunction

    function automatic t_out predict_result(t_in item);
        t_out        res;
        logic [31:0] v;
        int          n;
        n = effective_size();
        if (item.operation == 1'(OP_REBUILD)) begin
            refill_residues(n);
            v = '0;
        end else begin
            v = item.value;
            for (int i = 0; i < int'(item.passes); i++) v = window_round(v, n);
        end
        res.hash_value = v;
        res.too_small  = (n < SMALL_LIMIT);
        return res;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_table_size(int size);
        start <= 1'b0;
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= SIZE_W'(size);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = size;
    endtask

    task automatic send_item(t_in item, bit typed, t_out typed_res);
        t_out res;
        if (sender_idle_pct > 0) begin
            while ($urandom_range(99) < sender_idle_pct) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start  <= 1'b1;
        i_item <= item;
        do @(posedge i_clk); while (busy);
        res = predict_result(item);
        if (typed) res = typed_res;
        pending_results.push_back(res);
        if (item.operation == 1'(OP_REBUILD)) rebuild_count++;
        else hash_count++;
        if (res.too_small) small_count++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("Unexpected result: hash_value %h too_small %b",
                       o_result.hash_value, o_result.too_small);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.hash_value !== want.hash_value) begin
                    $error("hash_value: expected %h, actual %h",
                           want.hash_value, o_result.hash_value);
                    mismatches++;
                end
                if (o_result.too_small !== want.too_small) begin
                    $error("too_small: expected %b, actual %b",
                           want.too_small, o_result.too_small);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_size();
        case ($urandom_range(9))
            0: return 3;
            1: return 33;
            2: return 34;
            3: return 35;
            4: return MAX_TABLE;
            5: return 2047;
            6: return $urandom_range(2047);
            default: return $urandom_range(300, 34);
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF - $urandom_range(40);
            1: return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_passes();
        int r;
        r = $urandom_range(999);
        if (r < 2) return 1023;
        if (r < 700) return $urandom_range(3);
        return $urandom_range(16, 4);
    endfunction

    initial begin
        t_row rows[$];
        t_in  item;
        t_out typed_res;
        int   n_left;
        int   seg;

        mismatches      = 0;
        idle_cycles     = 0;
        hash_count      = 0;
        rebuild_count   = 0;
        small_count     = 0;
        sender_idle_pct = 0;
        size_reg        = MAX_TABLE;
        foreach (residue_bits[k]) residue_bits[k] = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // size, operation, value, passes, typed, expected hash, expected flag
        rows = '{
            '{1024, 1'b1, 32'hDEAD_BEEF, 2,    1'b1, 32'h0,         1'b0},
            '{1024, 1'b1, 32'hFFFF_FFFF, 0,    1'b1, 32'hFFFF_FFFF, 1'b0},
            '{2047, 1'b0, 32'hFFFF_FFFF, 2047, 1'b1, 32'h0,         1'b0},
            '{2047, 1'b1, 32'h0,         1,    1'b0, 32'h0,         1'b0},
            '{2047, 1'b1, 32'hFFFF_FFFF, 3,    1'b0, 32'h0,         1'b0},
            '{33,   1'b1, 32'h1234_5678, 5,    1'b1, 32'hFFFF_FFFF, 1'b1},
            '{33,   1'b1, 32'h1234_5678, 0,    1'b1, 32'h1234_5678, 1'b1},
            '{33,   1'b0, 32'h0,         0,    1'b1, 32'h0,         1'b1},
            '{0,    1'b0, 32'h0,         0,    1'b1, 32'h0,         1'b1},
            '{0,    1'b1, 32'h5555_AAAA, 1,    1'b1, 32'hFFFF_FFFF, 1'b1},
            '{1,    1'b0, 32'h0,         0,    1'b1, 32'h0,         1'b1},
            '{2,    1'b0, 32'h0,         0,    1'b1, 32'h0,         1'b1},
            '{3,    1'b0, 32'h0,         0,    1'b1, 32'h0,         1'b1},
            '{34,   1'b1, 32'h0000_00FF, 2,    1'b0, 32'h0,         1'b0},
            '{34,   1'b0, 32'h0,         0,    1'b1, 32'h0,         1'b0},
            '{34,   1'b1, 32'hFFFF_FFF0, 2,    1'b0, 32'h0,         1'b0},
            '{34,   1'b1, 32'h8000_0000, 1024, 1'b0, 32'h0,         1'b0},
            '{2047, 1'b1, 32'h0000_0007, 2,    1'b0, 32'h0,         1'b0},
            '{100,  1'b0, 32'h0,         0,    1'b1, 32'h0,         1'b0},
            '{100,  1'b1, 32'hA5A5_5A5A, 1,    1'b0, 32'h0,         1'b0},
            '{100,  1'b1, 32'h0000_0061, 4,    1'b0, 32'h0,         1'b0},
            '{1024, 1'b1, 32'h7FFF_FFFF, 2,    1'b0, 32'h0,         1'b0}
        };

        foreach (rows[r]) begin
            if (rows[r].size != size_reg || r == 0) write_table_size(rows[r].size);
            item.operation       = rows[r].op;
            item.value           = rows[r].value;
            item.passes          = SIZE_W'(rows[r].passes);
            typed_res.hash_value = rows[r].exp_hash;
            typed_res.too_small  = rows[r].exp_small;
            send_item(item, rows[r].typed, typed_res);
        end

        n_left = RANDOM_ITEMS;
        seg = 0;
        while (n_left > 0) begin
            sender_idle_pct = (n_left > 2 * RANDOM_ITEMS / 3) ? 38 :
                              (n_left > RANDOM_ITEMS / 3) ? 48 : 0;
            write_table_size(pick_size());
            if (seg % 2 == 0 && effective_size() <= 300) begin
                item = '{operation: 1'(OP_REBUILD), value: $urandom,
                         passes: SIZE_W'($urandom)};
                send_item(item, 1'b0, typed_res);
            end
            for (int i = 0; i < 120 && n_left > 0; i++) begin
                item.operation = 1'(OP_HASH);
                item.value     = pick_value();
                item.passes    = SIZE_W'(pick_passes());
                if ($urandom_range(19) == 0 && effective_size() <= 300) begin
                    item.operation = 1'(OP_REBUILD);
                end
                if (i == 60) begin
                    start <= 1'b0;
                    wait_drained();
                    @(negedge i_clk);
                end
                send_item(item, 1'b0, typed_res);
                n_left--;
            end
            seg++;
        end

        start <= 1'b0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d hash and %0d rebuild transactions, %0d with a small table,",
                 hash_count, rebuild_count, small_count);
        $display("over %0d table size settings with and without sender idling.", seg + 1);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> prime_residue_bit_hash_core.f
sv/prbh_pkg.sv
sv/prbh_div.sv
sv/prbh_datapath.sv
sv/prbh_ctrl.sv
sv/prime_residue_bit_hash_core.sv
tb/tb_prime_residue_bit_hash_core.sv
